/* src/pie_pkg.sv */
package pie_pkg;

  localparam int IDX_W = 16;

  localparam logic [2:0] KIND_QUADS = 3'd0;
  localparam logic [2:0] KIND_TRIS  = 3'd1;
  localparam logic [2:0] KIND_FAN   = 3'd2;
  localparam logic [2:0] KIND_STRIP = 3'd3;
  localparam logic [2:0] KIND_LINES = 3'd4;

  localparam logic [IDX_W-1:0] OFS_M2 = 16'hFFFE;
  localparam logic [IDX_W-1:0] OFS_M1 = 16'hFFFF;
  localparam logic [IDX_W-1:0] OFS_0  = 16'h0000;
  localparam logic [IDX_W-1:0] OFS_1  = 16'h0001;
  localparam logic [IDX_W-1:0] OFS_2  = 16'h0002;
  localparam logic [IDX_W-1:0] OFS_3  = 16'h0003;

  typedef struct packed {
    logic [2:0]       prim_kind;
    logic [IDX_W-1:0] base_index;
    logic             first_vertex;
    logic             last_vertex;
  } vtx_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] index_value;
    logic             run_end;
  } idx_word_t;

  // What the back end has to emit for one vertex.
  typedef enum logic [2:0] {
    OP_SINGLE     = 3'd0,
    OP_QUAD       = 3'd1,
    OP_FAN        = 3'd2,
    OP_STRIP_EVEN = 3'd3,
    OP_STRIP_ODD  = 3'd4,
    OP_LINES      = 3'd5
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] anchor;
    logic [IDX_W-1:0] base;
  } job_t;

  function automatic logic [2:0] op_len(op_t op);
    case (op)
      OP_SINGLE:                             op_len = 3'd1;
      OP_FAN, OP_STRIP_EVEN, OP_STRIP_ODD:   op_len = 3'd3;
      OP_QUAD, OP_LINES:                     op_len = 3'd6;
      default:                               op_len = 3'd1;
    endcase
  endfunction

  // Offset added to the anchor index at each step of a job.
  function automatic logic [IDX_W-1:0] step_offset(op_t op, logic [2:0] step);
    logic [IDX_W-1:0] ofs;
    ofs = OFS_0;
    case (op)
      OP_QUAD: begin
        case (step)
          3'd1:       ofs = OFS_1;
          3'd2, 3'd3: ofs = OFS_2;
          3'd4:       ofs = OFS_3;
          default:    ofs = OFS_0;
        endcase
      end
      OP_LINES: begin
        case (step)
          3'd1:       ofs = OFS_1;
          3'd2, 3'd3: ofs = OFS_3;
          3'd4:       ofs = OFS_2;
          default:    ofs = OFS_0;
        endcase
      end
      OP_FAN: begin
        ofs = (step == 3'd1) ? OFS_M1 : OFS_0;
      end
      OP_STRIP_EVEN: begin
        case (step)
          3'd0:    ofs = OFS_M2;
          3'd1:    ofs = OFS_M1;
          default: ofs = OFS_0;
        endcase
      end
      OP_STRIP_ODD: begin
        case (step)
          3'd0:    ofs = OFS_M1;
          3'd1:    ofs = OFS_M2;
          default: ofs = OFS_0;
        endcase
      end
      default: ofs = OFS_0;
    endcase
    return ofs;
  endfunction

endpackage

/* src/pie_front.sv */
module pie_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              vtx_valid,
  output logic              vtx_stall,
  input  pie_pkg::vtx_word_t vtx,
  input  logic              full,
  output logic              push,
  output pie_pkg::job_t     push_job
);
  import pie_pkg::*;

  logic [IDX_W-1:0] position;
  logic [2:0]       held_kind;
  logic [IDX_W-1:0] held_base;

  logic             accept;
  logic [IDX_W-1:0] p;
  logic [2:0]       kind;
  logic [IDX_W-1:0] base;
  logic [IDX_W-1:0] p_sel;
  logic [IDX_W-1:0] anchor;
  logic             emit;
  op_t              op;

  assign vtx_stall = full;
  assign accept    = vtx_valid && !full;

  assign p    = vtx.first_vertex ? '0 : position;
  assign kind = vtx.first_vertex ? vtx.prim_kind : held_kind;
  assign base = vtx.first_vertex ? vtx.base_index : held_base;

  // Quads anchor on the first vertex of their group of four.
  assign p_sel  = (kind == KIND_QUADS) ? {p[IDX_W-1:2], 2'b00} : p;
  assign anchor = (kind == KIND_LINES) ? '0 : base + p_sel;

  always_comb begin
    emit = 1'b0;
    op   = OP_SINGLE;
    case (kind)
      KIND_QUADS: begin
        emit = (p[1:0] == 2'b11) || vtx.last_vertex;
        op   = OP_QUAD;
      end
      KIND_TRIS: begin
        emit = 1'b1;
        op   = OP_SINGLE;
      end
      KIND_FAN: begin
        emit = 1'b1;
        op   = (p < IDX_W'(3)) ? OP_SINGLE : OP_FAN;
      end
      KIND_STRIP: begin
        emit = 1'b1;
        if (p < IDX_W'(3)) begin
          op = OP_SINGLE;
        end else if (p[0]) begin
          op = OP_STRIP_ODD;
        end else begin
          op = OP_STRIP_EVEN;
        end
      end
      KIND_LINES: begin
        emit = (p == '0);
        op   = OP_LINES;
      end
      default: begin
        emit = 1'b0;
        op   = OP_SINGLE;
      end
    endcase
  end

  assign push            = accept && emit;
  assign push_job.op     = op;
  assign push_job.anchor = anchor;
  assign push_job.base   = base;

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      held_kind <= '0;
      held_base <= '0;
    end else if (accept) begin
      position  <= p + IDX_W'(1);
      held_kind <= kind;
      held_base <= base;
    end
  end

endmodule

/* src/pie_queue.sv */
module pie_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pie_pkg::job_t push_job,
  output logic          full,
  output logic          head_valid,
  output pie_pkg::job_t head_job,
  input  logic          pop
);
  import pie_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CNT_W'(1))
    else $error("queue count did not follow a write");
`endif

endmodule

/* src/pie_back.sv */
module pie_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  pie_pkg::job_t      head_job,
  output logic               pop,
  output logic               idx_valid,
  input  logic               idx_stall,
  output pie_pkg::idx_word_t idx
);
  import pie_pkg::*;

  logic [2:0]       step;
  logic             advance;
  logic             last_step;
  logic [IDX_W-1:0] value;

  assign advance   = head_valid && (!idx_valid || !idx_stall);
  assign last_step = (step == op_len(head_job.op) - 3'd1);
  assign pop       = advance && last_step;

  // A fan opens every triangle with the draw's base index.
  assign value = (head_job.op == OP_FAN && step == 3'd0) ? head_job.base
               : head_job.anchor + step_offset(head_job.op, step);

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      idx_valid <= 1'b0;
    end else if (advance) begin
      step      <= last_step ? 3'd0 : step + 3'd1;
      idx_valid <= 1'b1;
    end else if (!idx_stall) begin
      idx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      idx.index_value <= value;
      idx.run_end     <= last_step;
    end
  end

`ifndef ASSERT_OFF
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> step < op_len(head_job.op))
    else $error("step counter ran past the job length");
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> step == 3'd0)
    else $error("step counter left mid-job with no job queued");
  a_pop_ends_run: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx_valid && idx.run_end)
    else $error("retired job did not close its run");
`endif

endmodule

/* src/primitive_index_expander.sv */
// Turns a stream of vertices, one word each, into a triangle-list index stream of one
// index word per cycle while idx_stall is low; the last index caused by a vertex carries
// run_end. A first vertex latches the primitive kind and base index and restarts the
// position count. The front end classifies each vertex in the cycle it is taken and
// queues a job of one, three or six indices; the back end walks that job one index per
// cycle through a registered output while idx_stall is low. A triangle vertex and each
// of the first three fan or strip vertices queue one index, a later fan or strip vertex
// three, a quad vertex that closes its group or ends the draw and the first line vertex
// six, and a vertex that emits nothing queues no job.
// Up to QUEUE_DEPTH jobs wait between the two ends, so input and output stall
// independently.
module primitive_index_expander #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               vtx_valid,
  output logic               vtx_stall,
  input  pie_pkg::vtx_word_t vtx,
  output logic               idx_valid,
  input  logic               idx_stall,
  output pie_pkg::idx_word_t idx
);
  import pie_pkg::*;

  logic full;
  logic push;
  job_t push_job;
  logic head_valid;
  job_t head_job;
  logic pop;

  pie_front u_front (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx       (vtx),
    .full      (full),
    .push      (push),
    .push_job  (push_job)
  );

  pie_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  pie_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .idx_valid  (idx_valid),
    .idx_stall  (idx_stall),
    .idx        (idx)
  );

endmodule

/* tb/sv/tb_primitive_index_expander.sv */
module tb_primitive_index_expander;
  import pie_pkg::*;

  localparam logic [2:0] KIND_UNKNOWN = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 295;
  localparam int DRAIN_CYCLES = 20;

  class index_scoreboard;
    idx_word_t expected_q[$];
    logic [IDX_W-1:0] position;
    logic [IDX_W-1:0] held_base;
    logic [2:0] held_kind;
    int errors;

    function new();
      position = '0;
      held_base = '0;
      held_kind = KIND_QUADS;
      errors = 0;
    endfunction

    function void push_index(logic [IDX_W-1:0] value);
      idx_word_t w;
      w.index_value = value;
      w.run_end = 1'b0;
      expected_q.push_back(w);
    endfunction

    function void push_quad(logic [IDX_W-1:0] g);
      push_index(g);
      push_index(g + 16'd1);
      push_index(g + 16'd2);
      push_index(g + 16'd2);
      push_index(g + 16'd3);
      push_index(g);
    endfunction

    // Expands one accepted vertex word into the index words it must produce.
    function void note_vertex(vtx_word_t w);
      logic [IDX_W-1:0] p;
      logic [IDX_W-1:0] i;
      idx_word_t tail;
      int before_count;
      if (w.first_vertex) begin
        held_kind = w.prim_kind;
        held_base = w.base_index;
        position = '0;
      end
      p = position;
      i = held_base + p;
      before_count = expected_q.size();
      case (held_kind)
        KIND_QUADS: begin
          if (p[1:0] == 2'd3 || w.last_vertex) begin
            push_quad(held_base + {p[IDX_W-1:2], 2'b00});
          end
        end
        KIND_TRIS: push_index(i);
        KIND_FAN: begin
          if (p < 16'd3) begin
            push_index(i);
          end else begin
            push_index(held_base);
            push_index(i - 16'd1);
            push_index(i);
          end
        end
        KIND_STRIP: begin
          if (p < 16'd3) begin
            push_index(i);
          end else if (!p[0]) begin
            push_index(i - 16'd2);
            push_index(i - 16'd1);
            push_index(i);
          end else begin
            push_index(i - 16'd1);
            push_index(i - 16'd2);
            push_index(i);
          end
        end
        KIND_LINES: begin
          if (p == 16'd0) begin
            push_index(16'd0);
            push_index(16'd1);
            push_index(16'd3);
            push_index(16'd3);
            push_index(16'd2);
            push_index(16'd0);
          end
        end
        default: ;
      endcase
      if (expected_q.size() > before_count) begin
        tail = expected_q.pop_back();
        tail.run_end = 1'b1;
        expected_q.push_back(tail);
      end
      position = p + 16'd1;
    endfunction

    function void check_index(idx_word_t got);
      idx_word_t want;
      if (expected_q.size() == 0) begin
        $error("index word %h arrived with nothing expected", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.index_value !== want.index_value) begin
        $error("index_value expected %h actual %h", want.index_value, got.index_value);
        errors++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_end expected %b actual %b", want.run_end, got.run_end);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vtx_valid = 1'b0;
  vtx_word_t vtx = '0;
  logic vtx_stall;
  logic idx_valid;
  logic idx_stall = 1'b0;
  idx_word_t idx;

  bit calm = 1'b0;
  int sent = 0;
  index_scoreboard sb = new();

  primitive_index_expander u_top (
    .clk(clk),
    .rst(rst),
    .vtx_valid(vtx_valid),
    .vtx_stall(vtx_stall),
    .vtx(vtx),
    .idx_valid(idx_valid),
    .idx_stall(idx_stall),
    .idx(idx)
  );

  always #5 clk = ~clk;

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 26);
  endfunction

  always @(posedge clk) begin
    idx_stall <= !rst && take_break();
  end

  // The input word is noted before the output is checked, so an expectation
  // always exists before its index word could be seen.
  always @(posedge clk) begin
    if (!rst) begin
      if (vtx_valid && !vtx_stall) sb.note_vertex(vtx);
      if (idx_valid && !idx_stall) sb.check_index(idx);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (vtx_valid && !vtx_stall) || (idx_valid && !idx_stall)) quiet = 0;
      else quiet++;
    end
    $display("primitive_index_expander test failed");
    $finish;
  end

  task automatic send_vertex(input logic [2:0] kind, input logic [IDX_W-1:0] base,
                             input bit first, input bit last);
    vtx_word_t w;
    w.prim_kind = kind;
    w.base_index = base;
    w.first_vertex = first;
    w.last_vertex = last;
    while (take_break()) begin
      vtx_valid <= 1'b0;
      @(posedge clk);
    end
    vtx_valid <= 1'b1;
    vtx <= w;
    do @(posedge clk); while (vtx_stall);
    sent++;
  endtask

  // Only the first vertex carries meaningful kind and base; the rest get noise there.
  task automatic send_draw(input logic [2:0] kind, input logic [IDX_W-1:0] base,
                           input int len);
    for (int k = 0; k < len; k++) begin
      if (k == 0) send_vertex(kind, base, 1'b1, len == 1);
      else send_vertex(3'($urandom_range(7)), 16'($urandom_range(16'hFFFF)), 1'b0,
                       k == len - 1);
    end
  endtask

  initial begin
    int target;
    int len;
    logic [2:0] kind;
    logic [IDX_W-1:0] base;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_draw(KIND_QUADS, 16'hFFFE, 4);
    send_draw(KIND_QUADS, 16'h1234, 2);
    send_draw(KIND_QUADS, 16'h0000, 1);
    send_draw(KIND_TRIS, 16'hFFFF, 3);
    send_draw(KIND_FAN, 16'hFFFD, 5);
    send_draw(KIND_STRIP, 16'hFFFE, 5);
    send_draw(KIND_LINES, 16'hFFFF, 3);
    send_vertex(KIND_UNKNOWN, 16'h8000, 1'b1, 1'b0);
    // A vertex with no first mark carries on with the held draw.
    send_vertex(KIND_FAN, 16'h5555, 1'b0, 1'b0);

    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      calm = (sent > target - 200) && (sent < target - 120);
      if ($urandom_range(99) < 85) begin
        kind = ($urandom_range(99) < 8) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
        base = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hFFF8, 16'hFFFF))
                                        : 16'($urandom_range(16'hFFFF));
        len = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 7);
        send_draw(kind, base, len);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_vertex(3'($urandom_range(7)), 16'($urandom_range(16'hFFFF)), 1'b0,
                      1'($urandom_range(1)));
        end
      end
    end
    calm = 1'b0;
    vtx_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("primitive_index_expander test passed");
    else $display("primitive_index_expander test failed");
    $finish;
  end

endmodule
